// ===== rtl/noise_floor_percentile_monitor_top_macros.svh =====
// ----------------------------------------------------------------------------
// noise floor monitor assertion macros
// shared property shapes for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef NOISE_FLOOR_PERCENTILE_MONITOR_TOP_MACROS_SVH
`define NOISE_FLOOR_PERCENTILE_MONITOR_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NFPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NFPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// nfpm_pkg
// types and fixed constants of the noise floor percentile monitor
// ----------------------------------------------------------------------------
package nfpm_pkg;

    localparam int SAMPLE_W = 9;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    localparam logic signed [SAMPLE_W-1:0] ALERT_LEVEL_RST = -9'sd90;
    localparam logic signed [SAMPLE_W-1:0] CLEAR_LEVEL_RST = -9'sd95;

    // register index, taken from paddr[2]
    localparam logic REG_ALERT_LEVEL = 1'b0;
    localparam logic REG_CLEAR_LEVEL = 1'b1;

    // item mode codes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EVAL,
        S_PUSH
    } t_state;

endpackage

// ===== rtl/nfpm_ram.sv =====
// ----------------------------------------------------------------------------
// nfpm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module nfpm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/noise_floor_percentile_monitor_top.sv =====
// ----------------------------------------------------------------------------
// noise_floor_percentile_monitor_top
// sliding-window noise floor estimate with a hysteresis alert
// ----------------------------------------------------------------------------
// Holds the last WINDOW_DEPTH RSSI samples taken while in receive mode and
// reports the sample of rank PERCENTILE_RANK (ascending, from 0) once at
// least MIN_HELD are held, plus an alert that sets at alert_level and clears
// at clear_level. Every input beat gives one result beat. A clear beat, a
// sample taken outside receive mode or a sample that leaves fewer than
// MIN_HELD held goes from the idle state straight to the push state and on
// into the output register. Any other stored sample takes P passes over the
// window, P <= min(PERCENTILE_RANK, H - 1) + 1 with H the held count.
// Each pass is made by a single compare unit walking the window ram through
// its one read port, one entry per cycle: it finds the next distinct value
// above the last one and counts its copies. Input ready is high only while
// the sequencer is idle; a finished result waits in the output register
// without holding up the next input beat. Registers: alert_level at byte 0,
// clear_level at byte 4, 9-bit signed, sign-extended on read.
// ----------------------------------------------------------------------------
module noise_floor_percentile_monitor_top #(
    parameter int WINDOW_DEPTH    = 16,
    parameter int PERCENTILE_RANK = 4,
    parameter int MIN_HELD        = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic                                  i_in_receive,
    input  logic signed [nfpm_pkg::SAMPLE_W-1:0]  i_rssi_sample,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_floor_valid,
    output logic signed [nfpm_pkg::SAMPLE_W-1:0]  o_noise_floor,
    output logic                                  o_alert,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [nfpm_pkg::PADDR_W-1:0]          paddr,
    input  logic [nfpm_pkg::PDATA_W-1:0]          pwdata,
    output logic [nfpm_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    import nfpm_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int RKW  = $clog2(PERCENTILE_RANK + 2);
    localparam int MW   = $clog2(MIN_HELD + 1);
    localparam int CMW0 = (CW > RKW) ? CW : RKW;
    localparam int CMPW = (CMW0 > MW) ? CMW0 : MW;

    localparam logic [CMPW-1:0] RANK_C    = CMPW'(PERCENTILE_RANK);
    localparam logic [CMPW-1:0] MIN_C     = CMPW'(MIN_HELD);
    localparam logic [CW-1:0]   DEPTH_C   = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0]   LAST_SLOT = AW'(WINDOW_DEPTH - 1);

    t_state r_state, n_state;

    logic [AW-1:0]                r_slot, n_slot;
    logic [CW-1:0]                r_held, n_held;
    logic                         r_alert, n_alert;
    logic signed [SAMPLE_W-1:0]   r_alert_level, n_alert_level;
    logic signed [SAMPLE_W-1:0]   r_clear_level, n_clear_level;
    logic signed [SAMPLE_W-1:0]   r_floor, n_floor;
    logic                         r_fvalid, n_fvalid;

    // selection unit
    logic [AW-1:0]                r_idx, n_idx;
    logic                         r_rd_vld, n_rd_vld;
    logic signed [SAMPLE_W-1:0]   r_thr, n_thr;
    logic                         r_have_thr, n_have_thr;
    logic signed [SAMPLE_W-1:0]   r_min, n_min;
    logic                         r_found, n_found;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                r_cum, n_cum;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_fvalid, n_out_fvalid;
    logic signed [SAMPLE_W-1:0]   r_out_floor, n_out_floor;
    logic                         r_out_alert, n_out_alert;

    logic                         w_in_acc;
    logic                         w_ram_we;
    logic                         w_rd_en;
    logic [SAMPLE_W-1:0]          w_rdata;
    logic signed [SAMPLE_W-1:0]   w_rd_data;
    logic [CW-1:0]                w_rank;
    logic                         w_cfg_wr;

    nfpm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (i_rssi_sample),
        .i_re    (w_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_data = w_rdata;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // rank limited to held_count - 1
    assign w_rank = (RANK_C >= CMPW'(r_held)) ? (r_held - CW'(1)) : RANK_C[CW-1:0];

    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_held        = r_held;
        n_alert       = r_alert;
        n_alert_level = r_alert_level;
        n_clear_level = r_clear_level;
        n_floor       = r_floor;
        n_fvalid      = r_fvalid;
        n_idx         = r_idx;
        n_rd_vld      = 1'b0;
        n_thr         = r_thr;
        n_have_thr    = r_have_thr;
        n_min         = r_min;
        n_found       = r_found;
        n_cnt         = r_cnt;
        n_cum         = r_cum;
        n_out_valid   = r_out_valid;
        n_out_fvalid  = r_out_fvalid;
        n_out_floor   = r_out_floor;
        n_out_alert   = r_out_alert;
        w_ram_we      = 1'b0;
        w_rd_en       = 1'b0;

        if (w_cfg_wr) begin
            if (paddr[2] == REG_ALERT_LEVEL) begin
                n_alert_level = pwdata[SAMPLE_W-1:0];
            end else begin
                n_clear_level = pwdata[SAMPLE_W-1:0];
            end
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // smallest value above the threshold, and how many copies of it
        if (r_rd_vld) begin
            if (!r_have_thr || (w_rd_data > r_thr)) begin
                if (!r_found || (w_rd_data < r_min)) begin
                    n_min   = w_rd_data;
                    n_cnt   = CW'(1);
                    n_found = 1'b1;
                end else if (w_rd_data == r_min) begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_mode == MODE_CLEAR) begin
                        n_held   = '0;
                        n_slot   = '0;
                        n_alert  = 1'b0;
                        n_floor  = '0;
                        n_fvalid = 1'b0;
                        n_state  = S_PUSH;
                    end else if (!i_in_receive) begin
                        n_state = S_PUSH;
                    end else begin
                        w_ram_we = 1'b1;
                        n_slot   = (r_slot == LAST_SLOT) ? '0 : r_slot + AW'(1);
                        n_held   = (r_held == DEPTH_C) ? r_held : r_held + CW'(1);
                        if (CMPW'(n_held) >= MIN_C) begin
                            n_idx      = '0;
                            n_have_thr = 1'b0;
                            n_found    = 1'b0;
                            n_cnt      = '0;
                            n_cum      = '0;
                            n_state    = S_SCAN;
                        end else begin
                            n_floor  = '0;
                            n_fvalid = 1'b0;
                            n_state  = S_PUSH;
                        end
                    end
                end
            end
            S_SCAN: begin
                w_rd_en  = 1'b1;
                n_rd_vld = 1'b1;
                n_idx    = r_idx + AW'(1);
                if (CW'(r_idx) == (r_held - CW'(1))) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read beat of the pass lands here
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if ((r_cum + r_cnt) > w_rank) begin
                    n_floor  = r_min;
                    n_fvalid = 1'b1;
                    if (!r_alert && (r_min >= r_alert_level)) begin
                        n_alert = 1'b1;
                    end else if (r_alert && (r_min <= r_clear_level)) begin
                        n_alert = 1'b0;
                    end
                    n_state = S_PUSH;
                end else begin
                    n_thr      = r_min;
                    n_have_thr = 1'b1;
                    n_cum      = r_cum + r_cnt;
                    n_cnt      = '0;
                    n_found    = 1'b0;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_fvalid = r_fvalid;
                    n_out_floor  = r_floor;
                    n_out_alert  = r_alert;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot        <= '0;
            r_held        <= '0;
            r_alert       <= 1'b0;
            r_alert_level <= ALERT_LEVEL_RST;
            r_clear_level <= CLEAR_LEVEL_RST;
            r_floor       <= '0;
            r_fvalid      <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_slot        <= n_slot;
            r_held        <= n_held;
            r_alert       <= n_alert;
            r_alert_level <= n_alert_level;
            r_clear_level <= n_clear_level;
            r_floor       <= n_floor;
            r_fvalid      <= n_fvalid;
            r_rd_vld      <= n_rd_vld;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_thr        <= n_thr;
        r_have_thr   <= n_have_thr;
        r_min        <= n_min;
        r_found      <= n_found;
        r_cnt        <= n_cnt;
        r_cum        <= n_cum;
        r_out_fvalid <= n_out_fvalid;
        r_out_floor  <= n_out_floor;
        r_out_alert  <= n_out_alert;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_floor_valid = r_out_fvalid;
    assign o_noise_floor = r_out_floor;
    assign o_alert       = r_out_alert;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLEAR_LEVEL)
                  ? {{(PDATA_W - SAMPLE_W){r_clear_level[SAMPLE_W-1]}}, r_clear_level}
                  : {{(PDATA_W - SAMPLE_W){r_alert_level[SAMPLE_W-1]}}, r_alert_level};

endmodule

// ===== rtl/nfpm_checker.sv =====
// ----------------------------------------------------------------------------
// nfpm_checker
// port-level checks of the noise floor monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "noise_floor_percentile_monitor_top_macros.svh"

module nfpm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic                                 o_floor_valid,
    input logic signed [nfpm_pkg::SAMPLE_W-1:0] o_noise_floor,
    input logic                                 o_alert
);

    import nfpm_pkg::*;

    // a stalled result beat keeps its payload
    `NFPM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_noise_floor) && $stable(o_floor_valid) && $stable(o_alert), "result changed while stalled")

    // one item in flight: ready drops right after an input beat
    `NFPM_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "input taken while busy")

    // no floor means the floor field reads zero
    `NFPM_ASSERT_NOW(a_floor_zero, o_out_valid && !o_floor_valid, o_noise_floor == '0, "floor not zero while invalid")

    // alert can only be raised from a valid floor and is dropped by a clear
    `NFPM_ASSERT_NOW(a_alert_floor, o_out_valid && o_alert, o_floor_valid, "alert without a valid floor")

endmodule

bind noise_floor_percentile_monitor_top nfpm_checker u_nfpm_checker (.*);

// ===== verif/noise_floor_percentile_monitor_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_floor_percentile_monitor_top_test
// Drives RSSI sample and channel-clear beats into the monitor. It recomputes
// the window, the rank-4 floor and the hysteresis alert for every accepted
// beat, and checks each result beat against the oldest prediction. Alert and
// clear levels are rewritten over the apb port between phases, with extremes
// included. Sender and receiver idle at random, and the receiver holds off
// once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module noise_floor_percentile_monitor_top_test;
    import nfpm_pkg::*;

    localparam int WIN_DEPTH   = 16;
    localparam int PCT_RANK    = 4;
    localparam int MIN_HELD_N  = 8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SEG_ITEMS   = 80;
    localparam int NUM_SEGS    = 6;
    localparam int JUNK_W      = PDATA_W - SAMPLE_W;

    typedef struct packed {
        logic                mode;
        logic                in_receive;
        logic [SAMPLE_W-1:0] rssi;
    } t_rssi_beat;

    typedef struct packed {
        logic                floor_valid;
        logic [SAMPLE_W-1:0] noise_floor;
        logic                alert;
    } t_floor_report;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic                       o_in_ready;
    logic                       i_mode        = 1'b0;
    logic                       i_in_receive  = 1'b0;
    logic signed [SAMPLE_W-1:0] i_rssi_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_ready   = 1'b0;
    logic                       o_floor_valid;
    logic signed [SAMPLE_W-1:0] o_noise_floor;
    logic                       o_alert;
    logic                       psel          = 1'b0;
    logic                       penable       = 1'b0;
    logic                       pwrite        = 1'b0;
    logic [PADDR_W-1:0]         paddr         = '0;
    logic [PDATA_W-1:0]         pwdata        = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    noise_floor_percentile_monitor_top #(
        .WINDOW_DEPTH    (WIN_DEPTH),
        .PERCENTILE_RANK (PCT_RANK),
        .MIN_HELD        (MIN_HELD_N)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_in_receive  (i_in_receive),
        .i_rssi_sample (i_rssi_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_floor_valid (o_floor_valid),
        .o_noise_floor (o_noise_floor),
        .o_alert       (o_alert),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predicted block state
    logic signed [SAMPLE_W-1:0] win [WIN_DEPTH];
    logic [3:0]                 wr_slot;
    int                         held;
    logic                       alarm;
    logic signed [SAMPLE_W-1:0] lvl_alert;
    logic signed [SAMPLE_W-1:0] lvl_clear;

    t_rssi_beat    pending_beats [$];
    t_floor_report expected_reports [$];

    int   beats_queued  = 0;
    int   beats_in      = 0;
    int   beats_out     = 0;
    int   err_count     = 0;
    int   idle_cycles   = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_cnt      = 0;
    logic stall_wanted  = 1'b0;
    logic stall_done    = 1'b0;
    logic in_taken      = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sample of rank PCT_RANK among the held entries, 0 when too few are held
    function automatic logic [SAMPLE_W-1:0] rank_floor(output logic ok);
        int rank;
        int below;
        int at_or_below;
        rank_floor = '0;
        ok = (held >= MIN_HELD_N) && (held > 0);
        if (ok) begin
            rank = (PCT_RANK < held) ? PCT_RANK : held - 1;
            for (int i = 0; i < held; i++) begin
                below = 0;
                at_or_below = 0;
                for (int j = 0; j < held; j++) begin
                    if (win[j] < win[i]) below++;
                    if (win[j] <= win[i]) at_or_below++;
                end
                if (below <= rank && rank < at_or_below) return win[i];
            end
        end
    endfunction

    function automatic t_floor_report absorb_beat(t_rssi_beat b);
        t_floor_report              r;
        logic                       ok;
        logic signed [SAMPLE_W-1:0] fl;
        if (b.mode == MODE_CLEAR) begin
            held = 0;
            wr_slot = '0;
            alarm = 1'b0;
        end else if (b.in_receive) begin
            win[wr_slot] = b.rssi;
            wr_slot = wr_slot + 1'b1;
            if (held < WIN_DEPTH) held++;
            fl = rank_floor(ok);
            if (ok) begin
                if (!alarm && fl >= lvl_alert) alarm = 1'b1;
                else if (alarm && fl <= lvl_clear) alarm = 1'b0;
            end
        end
        r.noise_floor = rank_floor(ok);
        r.floor_valid = ok;
        r.alert = alarm;
        return r;
    endfunction

    // input driver
    always @(negedge i_clk) begin
        t_rssi_beat b;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                b = pending_beats.pop_front();
                i_in_valid    <= 1'b1;
                i_mode        <= b.mode;
                i_in_receive  <= b.in_receive;
                i_rssi_sample <= b.rssi;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (stall_wanted && !stall_done) begin
            hold_cnt    <= HOLD_CYCLES;
            stall_done  <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on input beats, check on result beats
    always @(posedge i_clk) begin
        t_rssi_beat    b;
        t_floor_report got;
        t_floor_report want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                b = {i_mode, i_in_receive, i_rssi_sample};
                expected_reports.push_back(absorb_beat(b));
                beats_in <= beats_in + 1;
            end
            if (o_out_valid && i_out_ready) begin
                beats_out <= beats_out + 1;
                got = {o_floor_valid, o_noise_floor, o_alert};
                if (expected_reports.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    err_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.floor_valid !== want.floor_valid) begin
                        $error("floor_valid expected %0d got %0d",
                            want.floor_valid, got.floor_valid);
                        err_count++;
                    end
                    if (got.noise_floor !== want.noise_floor) begin
                        $error("noise_floor expected %0d got %0d",
                            $signed(want.noise_floor), $signed(got.noise_floor));
                        err_count++;
                    end
                    if (got.alert !== want.alert) begin
                        $error("alert expected %0d got %0d", want.alert, got.alert);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic queue_beat(input logic mode, input logic rx, input logic [SAMPLE_W-1:0] v);
        pending_beats.push_back('{mode: mode, in_receive: rx, rssi: v});
        beats_queued++;
    endtask

    // write a level register, then read it back sign-extended
    task automatic cfg_write(input logic idx, input int level);
        logic [SAMPLE_W-1:0] lv;
        logic [JUNK_W-1:0]   junk;
        logic [PDATA_W-1:0]  want;
        lv = SAMPLE_W'(level);
        junk = JUNK_W'($urandom());
        want = {{JUNK_W{lv[SAMPLE_W-1]}}, lv};
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, lv};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_ALERT_LEVEL) lvl_alert = lv;
        else lvl_clear = lv;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("prdata expected %h got %h", want, prdata);
            err_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every queued beat has come back, then let the block go quiet
    task automatic settle();
        while (beats_out != beats_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_level(int lo, int hi);
        int k;
        k = $urandom_range(99);
        if (k < 60) return SAMPLE_W'(lo + int'($urandom_range(hi - lo)));
        else if (k < 80) return SAMPLE_W'($urandom());
        else return SAMPLE_W'(lo + (hi - lo) / 2 + 3 * int'($urandom_range(2)));
    endfunction

    initial begin
        int alert_set [NUM_SEGS];
        int clear_set [NUM_SEGS];
        int a;
        int c;
        int lo;
        int hi;
        int pick;

        alert_set = '{-60, 255, -256, 0, 0, -90};
        clear_set = '{-75, -256, 255, 0, 0, -95};
        wr_slot   = '0;
        held      = 0;
        alarm     = 1'b0;
        lvl_alert = ALERT_LEVEL_RST;
        lvl_clear = CLEAR_LEVEL_RST;
        send_idle_pct = 15;
        recv_idle_pct = 45;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset levels
        queue_beat(MODE_SAMPLE, 1'b0, 9'd255);     // ignored, nothing held
        queue_beat(MODE_CLEAR, 1'b1, -9'sd256);    // clear of an empty window
        queue_beat(MODE_SAMPLE, 1'b1, -9'sd256);
        queue_beat(MODE_SAMPLE, 1'b1, 9'sd255);
        queue_beat(MODE_SAMPLE, 1'b1, -9'sd100);
        queue_beat(MODE_SAMPLE, 1'b1, -9'sd90);
        queue_beat(MODE_SAMPLE, 1'b1, -9'sd85);
        queue_beat(MODE_SAMPLE, 1'b1, -9'sd80);
        queue_beat(MODE_SAMPLE, 1'b1, -9'sd95);
        queue_beat(MODE_SAMPLE, 1'b1, -9'sd70);    // eighth sample, alert sets
        queue_beat(MODE_SAMPLE, 1'b0, -9'sd256);   // not receiving, state held
        repeat (4) queue_beat(MODE_SAMPLE, 1'b1, -9'sd120);  // duplicates, alert clears
        repeat (6) queue_beat(MODE_SAMPLE, 1'b1, 9'sd0);     // fill and wrap the ring
        queue_beat(MODE_CLEAR, 1'b0, 9'sd0);
        queue_beat(MODE_SAMPLE, 1'b1, -9'sd256);
        settle();

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            send_idle_pct = (seg < 2) ? 15 : (seg < 4) ? 45 : 0;
            recv_idle_pct = (seg < 2) ? 45 : (seg < 4) ? 15 : 0;
            a = alert_set[seg];
            c = clear_set[seg];
            if (seg == 3 || seg == 4) begin
                a = int'($urandom_range(511)) - 256;
                c = int'($urandom_range(511)) - 256;
            end
            cfg_write(REG_ALERT_LEVEL, a);
            cfg_write(REG_CLEAR_LEVEL, c);
            lo = ((a < c) ? a : c) - 12;
            hi = ((a > c) ? a : c) + 12;
            if (lo < -256) lo = -256;
            if (hi > 255) hi = 255;
            if (seg == NUM_SEGS - 1) stall_wanted = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    queue_beat(MODE_CLEAR, 1'($urandom_range(1)), SAMPLE_W'($urandom()));
                end else if (pick < 16) begin
                    queue_beat(MODE_SAMPLE, 1'b0, SAMPLE_W'($urandom()));
                end else begin
                    queue_beat(MODE_SAMPLE, 1'b1, pick_level(lo, hi));
                end
            end
            settle();
        end

        repeat (100) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d predicted results never arrived", expected_reports.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
